// ===== src/dqb_pkg.sv =====
// dqb_pkg: shared types and codes for the double-ended queue buffer
// holds the input and result word structs, command and status codes
// no dependencies
package dqb_pkg;

  localparam int unsigned WORD_W = 32;

  // command codes
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_REAR   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [WORD_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     queue_empty;
    logic [1:0]               status;
  } out_word_t;

  // pointer update request from the control logic
  typedef struct packed {
    logic       upd;
    logic [1:0] cmd;
  } ptr_op_t;

endpackage

// ===== src/double_ended_queue_buffer.sv =====
// double_ended_queue_buffer: deque of signed 32-bit words in a ring store
// a push, failed pop, or pop that empties the queue is registered to out_data;
// a pop that leaves entries first does one ram read for the new front or rear
// pushes: 1 word per cycle unless out_stall holds; no new word during such a pop
// reset: head, count and valid flags cleared; ram contents untouched, no
// clearing pass, so words are accepted right after reset
module double_ended_queue_buffer #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dqb_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dqb_pkg::out_word_t out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic signed [dqb_pkg::WORD_W-1:0] NONE_VALUE = '1;

  // pointer unit outputs
  dqb_pkg::ptr_op_t ptr_op;
  logic [AW-1:0]    head_inc, head_dec, tail_inc, tail_dec;
  logic             is_empty, is_full, more_than_one;

  // ram ports
  logic                              ram_we, ram_re;
  logic [AW-1:0]                     ram_waddr, ram_raddr;
  logic signed [dqb_pkg::WORD_W-1:0] ram_rdata;

  // cached front and rear words, valid while the queue is not empty
  logic signed [dqb_pkg::WORD_W-1:0] front_r, front_nxt;
  logic signed [dqb_pkg::WORD_W-1:0] rear_r, rear_nxt;

  // a pop waiting on the ram read
  logic rd_pend_r, rd_pend_nxt;
  logic pend_front_r, pend_front_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  dqb_pkg::out_word_t out_data_r, out_data_nxt;

  logic out_free, acc, is_push, cmd_front, done_rd, load_now;

  // result register free this cycle if empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = rd_pend_r || !out_free;
  assign acc      = in_valid && !in_stall;

  assign is_push   = !in_data.cmd[1];
  assign cmd_front = (in_data.cmd == dqb_pkg::CMD_PUSH_FRONT) ||
                     (in_data.cmd == dqb_pkg::CMD_POP_FRONT);

  // pointer update only for a push with room or a pop with entries
  assign ptr_op.upd = acc && (is_push ? !is_full : !is_empty);
  assign ptr_op.cmd = in_data.cmd;

  dqb_ptr #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ptr (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (ptr_op),
    .head_inc     (head_inc),
    .head_dec     (head_dec),
    .tail_inc     (tail_inc),
    .tail_dec     (tail_dec),
    .is_empty     (is_empty),
    .is_full      (is_full),
    .more_than_one(more_than_one)
  );

  // push writes below the head or past the tail
  assign ram_we    = acc && is_push && !is_full;
  assign ram_waddr = cmd_front ? head_dec : tail_inc;

  // pop that leaves entries fetches the new front or rear
  assign ram_re    = acc && !is_push && more_than_one;
  assign ram_raddr = cmd_front ? head_inc : tail_dec;

  dqb_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data.push_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign done_rd  = rd_pend_r && out_free;
  assign load_now = acc && !ram_re;

  always_comb begin
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    rd_pend_nxt    = rd_pend_r;
    pend_front_nxt = pend_front_r;
    out_data_nxt   = out_data_r;

    if (done_rd) begin
      // ram word replaces the end that was popped
      if (pend_front_r) begin
        front_nxt = ram_rdata;
      end else begin
        rear_nxt = ram_rdata;
      end
      rd_pend_nxt              = 1'b0;
      out_data_nxt.front_value = pend_front_r ? ram_rdata : front_r;
      out_data_nxt.rear_value  = pend_front_r ? rear_r : ram_rdata;
      out_data_nxt.queue_empty = 1'b0;
      out_data_nxt.status      = dqb_pkg::ST_OK;
    end else if (ram_re) begin
      rd_pend_nxt    = 1'b1;
      pend_front_nxt = cmd_front;
    end else if (load_now) begin
      if (is_push) begin
        if (is_full) begin
          // dropped, queue unchanged and not empty
          out_data_nxt.front_value = front_r;
          out_data_nxt.rear_value  = rear_r;
          out_data_nxt.queue_empty = 1'b0;
          out_data_nxt.status      = dqb_pkg::ST_PUSH_FULL;
        end else begin
          // push onto empty queue makes the word both front and rear
          if (cmd_front || is_empty) begin
            front_nxt = in_data.push_value;
          end
          if (!cmd_front || is_empty) begin
            rear_nxt = in_data.push_value;
          end
          out_data_nxt.front_value = (cmd_front || is_empty) ? in_data.push_value : front_r;
          out_data_nxt.rear_value  = (!cmd_front || is_empty) ? in_data.push_value : rear_r;
          out_data_nxt.queue_empty = 1'b0;
          out_data_nxt.status      = dqb_pkg::ST_OK;
        end
      end else begin
        // pop on empty, or pop of the last entry: queue ends empty
        out_data_nxt.front_value = NONE_VALUE;
        out_data_nxt.rear_value  = NONE_VALUE;
        out_data_nxt.queue_empty = 1'b1;
        out_data_nxt.status      = is_empty ? dqb_pkg::ST_POP_EMPTY : dqb_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    if (done_rd || load_now) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    front_r      <= front_nxt;
    rear_r       <= rear_nxt;
    pend_front_r <= pend_front_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/dqb_ram.sv =====
// dqb_ram: entry store of the queue, one write and one read port
// read data registered; uses dqb_pkg
module dqb_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [dqb_pkg::WORD_W-1:0] wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic signed [dqb_pkg::WORD_W-1:0] rdata
);

  logic signed [dqb_pkg::WORD_W-1:0] mem [DEPTH];
  logic signed [dqb_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/dqb_ptr.sv =====
// dqb_ptr: head index, tail index and entry count of the ring
// tail is kept as head + count - 1 mod depth, also when empty; uses dqb_pkg
module dqb_ptr #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dqb_pkg::ptr_op_t op,
  output logic [AW-1:0]    head_inc,
  output logic [AW-1:0]    head_dec,
  output logic [AW-1:0]    tail_inc,
  output logic [AW-1:0]    tail_dec,
  output logic             is_empty,
  output logic             is_full,
  output logic             more_than_one
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // ring neighbors without a modulo
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;

  assign is_empty      = (count_r == '0);
  assign is_full       = (count_r == CW'(DEPTH));
  assign more_than_one = (count_r > CW'(1));

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (op.upd) begin
      unique case (op.cmd)
        dqb_pkg::CMD_PUSH_FRONT: begin
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
        end
        dqb_pkg::CMD_PUSH_REAR: begin
          tail_nxt  = tail_inc;
          count_nxt = count_r + 1'b1;
        end
        dqb_pkg::CMD_POP_FRONT: begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
        default: begin
          tail_nxt  = tail_dec;
          count_nxt = count_r - 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= LAST_IDX;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
